@@ rtl/core/wmep_pkg.sv @@
// Package for the windowed minimum energy path block.
// Holds shared widths, defaults and the control struct for the compare unit.
// No dependencies.
package wmep_pkg;

  // Fixed field widths
  localparam int HEIGHT_IN_W = 16;
  localparam int ENERGY_W    = 32;
  localparam int JW_W        = 4;

  // Parameter defaults
  localparam int MAX_WINDOW_DEF  = 8;
  localparam int HEIGHT_BITS_DEF = 16;

  // Register reset value and saturation limit
  localparam logic [JW_W-1:0]     JW_RESET   = 4'd1;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 32'hFFFF_FFFF;

  // Controls for the shared candidate unit
  typedef struct packed {
    logic load;  // start a new item
    logic zero;  // start value is zero (no earlier step held)
    logic step;  // fold one candidate into the running minimum
  } unit_ctrl_t;

endpackage

@@ rtl/core/wmep_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module wmep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wmep_unit.sv @@
// Shared candidate unit: absolute height difference, saturating add, running minimum.
// Depends on wmep_pkg.
module wmep_unit #(
  parameter int HW = wmep_pkg::HEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  wmep_pkg::unit_ctrl_t             ctrl,
  input  logic [HW-1:0]                    h,
  input  logic [HW-1:0]                    hist_height,
  input  logic [wmep_pkg::ENERGY_W-1:0]    hist_energy,
  output logic [wmep_pkg::ENERGY_W-1:0]    acc
);

  logic [HW-1:0]                     diff;
  logic [wmep_pkg::ENERGY_W:0]       sum;
  logic [wmep_pkg::ENERGY_W-1:0]     cand;

  // Candidate energy = earlier energy + |height difference|, saturated
  always_comb begin
    diff = (h >= hist_height) ? (h - hist_height) : (hist_height - h);
    sum  = {1'b0, hist_energy} + (wmep_pkg::ENERGY_W + 1)'(diff);
    cand = sum[wmep_pkg::ENERGY_W] ? wmep_pkg::ENERGY_MAX : sum[wmep_pkg::ENERGY_W-1:0];
  end

  // Load the start value or keep the smaller candidate
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= ctrl.zero ? '0 : wmep_pkg::ENERGY_MAX;
    end else if (ctrl.step && (cand < acc)) begin
      acc <= cand;
    end
  end

endmodule

@@ rtl/core/windowed_min_energy_path.sv @@
// Windowed minimum energy path: least energy per step. Uses wmep_pkg, wmep_ram, wmep_unit.
// Effective window W: jump_window clamped to 1..MAX_WINDOW, limited by the steps held.
// The input stalls while an item is in work; one candidate per cycle goes
// through the shared unit after a registered RAM read; a stalled result holds the write.
// Reset (rst, sync) clears history count, ring pointer and output valid; jump_window = 1.
module windowed_min_energy_path #(
  parameter int MAX_WINDOW  = wmep_pkg::MAX_WINDOW_DEF,
  parameter int HEIGHT_BITS = wmep_pkg::HEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               jump_window_we,
  input  logic [wmep_pkg::JW_W-1:0]          jump_window,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wmep_pkg::HEIGHT_IN_W-1:0]   height,
  input  logic                               first_step,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wmep_pkg::ENERGY_W-1:0]      min_energy
);

  localparam int HW    = (HEIGHT_BITS < wmep_pkg::HEIGHT_IN_W) ? HEIGHT_BITS
                                                                : wmep_pkg::HEIGHT_IN_W;
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int WIN_W = (CNT_W > wmep_pkg::JW_W) ? CNT_W : wmep_pkg::JW_W;
  localparam int RAM_W = HW + wmep_pkg::ENERGY_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_WRITE = 4'b0100,
    S_SPARE = 4'b1000
  } state_t;

  state_t                        state;
  logic [wmep_pkg::JW_W-1:0]     jw;
  logic [HW-1:0]                 h_reg;
  logic [CNT_W-1:0]              issue_left;
  logic [CNT_W-1:0]              steps_seen;
  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W-1:0]              write_pos;
  logic                          dv;

  logic                          accept;
  logic                          out_free;
  logic                          ram_we;
  logic [WIN_W-1:0]              jw_ext;
  logic [WIN_W-1:0]              win_clamp;
  logic [WIN_W-1:0]              seen_ext;
  logic [CNT_W-1:0]              win;
  logic [PTR_W-1:0]              wp_prev;
  logic [PTR_W-1:0]              rd_prev;
  logic [RAM_W-1:0]              ram_rdata;
  logic [wmep_pkg::ENERGY_W-1:0] acc;
  wmep_pkg::unit_ctrl_t          uctrl;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign ram_we   = (state == S_WRITE) && out_free;

  // Effective window: clamp the register, then limit by the steps held
  always_comb begin
    jw_ext    = WIN_W'(jw);
    if (jw_ext == '0) begin
      win_clamp = WIN_W'(1);
    end else if (jw_ext > WIN_W'(MAX_WINDOW)) begin
      win_clamp = WIN_W'(MAX_WINDOW);
    end else begin
      win_clamp = jw_ext;
    end
    seen_ext = first_step ? '0 : WIN_W'(steps_seen);
    win      = (win_clamp < seen_ext) ? CNT_W'(win_clamp) : CNT_W'(seen_ext);
  end

  // Step ring pointers back with wrap
  assign wp_prev = (write_pos == '0) ? PTR_W'(MAX_WINDOW - 1) : write_pos - PTR_W'(1);
  assign rd_prev = (rd_ptr == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr - PTR_W'(1);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      jw         <= wmep_pkg::JW_RESET;
      issue_left <= '0;
      steps_seen <= '0;
      write_pos  <= '0;
      dv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (jump_window_we) begin
        jw <= jump_window;
      end
      dv <= (state == S_RUN) && (issue_left != '0);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (first_step) begin
              steps_seen <= '0;
            end
            issue_left <= win;
            rd_ptr     <= wp_prev;
            state      <= (win == '0) ? S_WRITE : S_RUN;
          end
        end
        S_RUN: begin
          if (issue_left != '0) begin
            issue_left <= issue_left - CNT_W'(1);
            rd_ptr     <= rd_prev;
          end else if (!dv) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            write_pos <= (write_pos == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                               : write_pos + PTR_W'(1);
            if (steps_seen != CNT_W'(MAX_WINDOW)) begin
              steps_seen <= steps_seen + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Load a finished item, drop a taken one
      if (ram_we) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the item height and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      h_reg <= height[HW-1:0];
    end
    if (ram_we) begin
      min_energy <= acc;
    end
  end

  assign uctrl.load = accept;
  assign uctrl.zero = (win == '0);
  assign uctrl.step = dv;

  wmep_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos),
    .wdata ({h_reg, acc}),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  wmep_unit #(
    .HW (HW)
  ) u_unit (
    .clk         (clk),
    .ctrl        (uctrl),
    .h           (h_reg),
    .hist_height (ram_rdata[RAM_W-1:wmep_pkg::ENERGY_W]),
    .hist_energy (ram_rdata[wmep_pkg::ENERGY_W-1:0]),
    .acc         (acc)
  );

  // History count never passes the ring depth
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    steps_seen <= CNT_W'(MAX_WINDOW))
    else $error("steps_seen above ring depth");

  // Outstanding reads never pass the ring depth
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_left <= CNT_W'(MAX_WINDOW))
    else $error("issue count above ring depth");

  // Read data returns only while the sequencer is comparing
  a_dv_run: assert property (@(posedge clk) disable iff (rst)
    dv |-> (state == S_RUN))
    else $error("read data valid outside compare phase");

  // An item with no history skips the compare phase
  a_no_hist: assert property (@(posedge clk) disable iff (rst)
    (accept && (win == '0)) |=> (state == S_WRITE))
    else $error("empty window did not go straight to write");

  // A finished item shows up at the output and frees the input
  a_finish: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (out_valid && (state == S_IDLE)))
    else $error("finished item not presented");

endmodule
